// ===== sv/fifo_queue_with_key_search_core_macros.svh =====
// assertion macros shared by the queue core
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_CORE_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_CORE_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define FQKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fqks assertion failed");

// next-cycle implication
`define FQKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fqks assertion failed");

`endif

// ===== sv/fqks_pkg.sv =====
package fqks_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 32;
  localparam int YEAR_W    = 12;
  localparam int REC_W     = ID_W + YEAR_W;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    clear;
    logic    push;
    logic    rd_head;
    logic    scan_init;
    logic    scan_step;
    logic    pop;
    logic    res_en;
    status_t res_status;
    logic    res_data;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic match;
    logic last;
  } stat_t;

endpackage

// ===== sv/fqks_ram.sv =====
module fqks_ram #(
  parameter int WIDTH = fqks_pkg::REC_W,
  parameter int DEPTH = fqks_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/fqks_ctrl.sv =====
module fqks_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  fqks_pkg::stat_t stat_i,
  output fqks_pkg::ctrl_t ctrl_o
);

  fqks_pkg::state_t state_r;
  fqks_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqks_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl_o    = '0;
    ctrl_o.res_status = fqks_pkg::ST_OK;
    busy      = 1'b1;
    case (state_r)
      fqks_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.load = 1'b1;
          state_nxt   = fqks_pkg::S_EXEC;
        end
      end
      fqks_pkg::S_EXEC: begin
        case (stat_i.cmd)
          fqks_pkg::CMD_CLEAR: begin
            ctrl_o.clear  = 1'b1;
            ctrl_o.res_en = 1'b1;
            state_nxt     = fqks_pkg::S_IDLE;
          end
          fqks_pkg::CMD_PUSH: begin
            ctrl_o.res_en = 1'b1;
            if (stat_i.full) begin
              ctrl_o.res_status = fqks_pkg::ST_FULL;
            end else begin
              ctrl_o.push = 1'b1;
            end
            state_nxt = fqks_pkg::S_IDLE;
          end
          fqks_pkg::CMD_POP: begin
            if (stat_i.empty) begin
              ctrl_o.res_en     = 1'b1;
              ctrl_o.res_status = fqks_pkg::ST_EMPTY;
              state_nxt         = fqks_pkg::S_IDLE;
            end else begin
              ctrl_o.rd_head = 1'b1;
              state_nxt      = fqks_pkg::S_POP_WAIT;
            end
          end
          default: begin
            if (stat_i.empty) begin
              ctrl_o.res_en     = 1'b1;
              ctrl_o.res_status = fqks_pkg::ST_MISSING;
              state_nxt         = fqks_pkg::S_IDLE;
            end else begin
              ctrl_o.rd_head   = 1'b1;
              ctrl_o.scan_init = 1'b1;
              state_nxt        = fqks_pkg::S_SCAN;
            end
          end
        endcase
      end
      fqks_pkg::S_POP_WAIT: begin
        ctrl_o.pop      = 1'b1;
        ctrl_o.res_en   = 1'b1;
        ctrl_o.res_data = 1'b1;
        state_nxt       = fqks_pkg::S_IDLE;
      end
      fqks_pkg::S_SCAN: begin
        if (stat_i.match) begin
          ctrl_o.res_en   = 1'b1;
          ctrl_o.res_data = 1'b1;
          state_nxt       = fqks_pkg::S_IDLE;
        end else if (stat_i.last) begin
          ctrl_o.res_en     = 1'b1;
          ctrl_o.res_status = fqks_pkg::ST_MISSING;
          state_nxt         = fqks_pkg::S_IDLE;
        end else begin
          ctrl_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = fqks_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/fqks_dp.sv =====
module fqks_dp #(
  parameter int DEPTH  = fqks_pkg::DEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_cmd,
  input  logic [fqks_pkg::ID_W-1:0]   in_student_id,
  input  logic [fqks_pkg::YEAR_W-1:0] in_birth_year,
  input  fqks_pkg::ctrl_t             ctrl_i,
  output fqks_pkg::stat_t             stat_o,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [fqks_pkg::ID_W-1:0]   out_found_id,
  output logic [fqks_pkg::YEAR_W-1:0] out_found_year,
  output logic [CNT_W-1:0]            out_entry_count,
  output logic                        out_is_empty
);

  localparam int YW = fqks_pkg::YEAR_W;
  localparam int RW = fqks_pkg::REC_W;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  fqks_pkg::cmd_t        cmd_r;
  logic [fqks_pkg::ID_W-1:0] key_r;
  logic [YW-1:0]         year_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [PTR_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;

  logic                      out_valid_r;
  fqks_pkg::status_t         res_status_r;
  logic [fqks_pkg::ID_W-1:0] res_id_r;
  logic [YW-1:0]             res_year_r;
  logic [CNT_W-1:0]          res_cnt_r;
  logic                      res_empty_r;

  logic [RW-1:0]             rd_data;
  logic [fqks_pkg::ID_W-1:0] rd_id;
  logic [YW-1:0]             rd_year;
  logic                      rd_en;
  logic [PTR_W-1:0]          rd_addr;

  assign rd_id   = rd_data[RW-1:YW];
  assign rd_year = rd_data[YW-1:0];
  assign rd_en   = ctrl_i.rd_head | ctrl_i.scan_step;
  assign rd_addr = ctrl_i.rd_head ? head_r : scan_ptr_r;

  fqks_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl_i.push),
    .wr_addr (tail_r),
    .wr_data ({key_r, year_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    scan_ptr_nxt = scan_ptr_r;
    remain_nxt   = remain_r;
    if (ctrl_i.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
    end
    if (ctrl_i.push) begin
      tail_nxt = next_ptr(tail_r);
      occ_nxt  = occ_r + 1'b1;
    end
    if (ctrl_i.pop) begin
      head_nxt = next_ptr(head_r);
      occ_nxt  = occ_r - 1'b1;
    end
    if (ctrl_i.scan_init) begin
      scan_ptr_nxt = next_ptr(head_r);
      remain_nxt   = occ_r;
    end
    if (ctrl_i.scan_step) begin
      scan_ptr_nxt = next_ptr(scan_ptr_r);
      remain_nxt   = remain_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= ctrl_i.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      cmd_r  <= fqks_pkg::cmd_t'(in_cmd);
      key_r  <= in_student_id;
      year_r <= in_birth_year;
    end
    scan_ptr_r <= scan_ptr_nxt;
    remain_r   <= remain_nxt;
    if (ctrl_i.res_en) begin
      res_status_r <= ctrl_i.res_status;
      res_id_r     <= ctrl_i.res_data ? rd_id : '0;
      res_year_r   <= ctrl_i.res_data ? rd_year : '0;
      res_cnt_r    <= occ_nxt;
      res_empty_r  <= (occ_nxt == '0);
    end
  end

  assign stat_o.cmd   = cmd_r;
  assign stat_o.full  = (occ_r == CNT_W'(DEPTH));
  assign stat_o.empty = (occ_r == '0);
  assign stat_o.match = (rd_id == key_r);
  assign stat_o.last  = (remain_r == CNT_W'(1));

  assign out_valid       = out_valid_r;
  assign out_status      = res_status_r;
  assign out_found_id    = res_id_r;
  assign out_found_year  = res_year_r;
  assign out_entry_count = res_cnt_r;
  assign out_is_empty    = res_empty_r;

endmodule

// ===== sv/fifo_queue_with_key_search_core.sv =====
// bounded first-in first-out queue of records (identifier and birth year) with
// search by key. a command beat is taken on a clock edge where start is high and
// busy is low; exactly one result beat follows, shown for one cycle with out_valid
// high, and the receiver cannot stall it, so it must take every result beat as it
// comes. clear, push, pop on an empty queue and search on an empty queue register
// their result from the execute state; a pop that returns a record goes on through
// the pop read wait state, and a search on a non-empty queue through the scan state,
// where it examines k records (1 up to the number held, so at most DEPTH). busy
// drops in the cycle the result is shown, so a new command may be taken there. the
// search is paced by the record store, a single ram with a registered read port,
// which the scan walks one record per cycle from head towards tail.
module fifo_queue_with_key_search_core #(
  parameter int DEPTH  = fqks_pkg::DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [fqks_pkg::ID_W-1:0]   in_student_id,
  input  logic [fqks_pkg::YEAR_W-1:0] in_birth_year,
  // result channel, one strobe per command
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [fqks_pkg::ID_W-1:0]   out_found_id,
  output logic [fqks_pkg::YEAR_W-1:0] out_found_year,
  output logic [CNT_W-1:0]            out_entry_count,
  output logic                        out_is_empty
);

  `include "fifo_queue_with_key_search_core_macros.svh"

  // command and status groups between controller and datapath
  fqks_pkg::ctrl_t ctrl;
  fqks_pkg::stat_t stat;

  // sequencer: idle, execute, pop read wait, scan
  fqks_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // pointers, occupancy, record store and result registers
  fqks_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_student_id   (in_student_id),
    .in_birth_year   (in_birth_year),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_id    (out_found_id),
    .out_found_year  (out_found_year),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  // a taken command keeps the block busy for at least the execute cycle
  `FQKS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // results never come on consecutive cycles
  `FQKS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // empty flag agrees with the count
  `FQKS_ASSERT_NOW(a_empty_flag, out_valid, out_is_empty == (out_entry_count == '0))
  // a refused push only happens on a full queue
  `FQKS_ASSERT_NOW(a_full_count, out_valid && (out_status == fqks_pkg::ST_FULL),
                   out_entry_count == CNT_W'(DEPTH))
  // a failed command returns no record
  `FQKS_ASSERT_NOW(a_fail_zero, out_valid && (out_status != fqks_pkg::ST_OK),
                   (out_found_id == '0) && (out_found_year == '0))

endmodule
